// ===== rtl/irt_pkg.sv =====
// Shared constants, status codes and controller/datapath interface types.
package irt_pkg;

  // Default table depth and stored time width.
  localparam int CAPACITY_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;

  // Fixed port widths.
  localparam int IN_W  = 32;
  localparam int ENT_W = 7;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

// ===== rtl/irt_dp.sv =====
// Datapath: interval table memory, overlap scan and commit of one request.
module irt_dp #(
  parameter int CAPACITY  = irt_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  irt_pkg::ctrl_t           ctrl,
  output irt_pkg::stat_t           stat,
  input  logic [irt_pkg::IN_W-1:0] req_start,
  input  logic [irt_pkg::IN_W-1:0] req_end,
  output logic                     done,
  output logic                     accepted,
  output logic [1:0]               status,
  output logic [irt_pkg::ENT_W-1:0] entries_used
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ENT_W = irt_pkg::ENT_W;

  // Each entry holds {start, end} of one stored interval.
  logic [2*TIME_BITS-1:0] mem [CAPACITY];
  logic [2*TIME_BITS-1:0] rd_data;

  logic [TIME_BITS-1:0] req_s;
  logic [TIME_BITS-1:0] req_e;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 rd_vld;
  logic                 overlap;
  logic                 hit;
  logic                 invalid;
  logic                 full;
  logic                 store;
  logic [1:0]           status_next;
  logic [TIME_BITS-1:0] slot_s;
  logic [TIME_BITS-1:0] slot_e;

  // Stored entries fill in order and are never freed, so the fill count
  // marks the valid entries and the lowest free one.
  assign stat.scan_done = (idx == count);

  // Overlap test against the entry read in the previous cycle.
  assign slot_s = rd_data[2*TIME_BITS-1:TIME_BITS];
  assign slot_e = rd_data[TIME_BITS-1:0];
  assign hit    = (slot_s < req_e) && (slot_e > req_s);

  // Final decision, checked in priority order.
  always_comb begin
    invalid     = (req_s >= req_e);
    full        = (count == CNT_W'(CAPACITY));
    store       = 1'b0;
    count_next  = count;
    status_next = irt_pkg::ST_OK;
    if (invalid) begin
      status_next = irt_pkg::ST_INVALID;
    end else if (overlap) begin
      status_next = irt_pkg::ST_OVERLAP;
    end else if (full) begin
      status_next = irt_pkg::ST_FULL;
    end else begin
      store      = 1'b1;
      count_next = count + CNT_W'(1);
    end
  end

  // Table memory: one read port for the scan, one write port for commit.
  always_ff @(posedge clk) begin
    if (ctrl.scan && !stat.scan_done) begin
      rd_data <= mem[idx[IDX_W-1:0]];
    end
    if (ctrl.commit && store) begin
      mem[count[IDX_W-1:0]] <= {req_s, req_e};
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      req_s <= TIME_BITS'(req_start);
      req_e <= TIME_BITS'(req_end);
    end
  end

  // Scan index, read pipeline flag and overlap accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      rd_vld  <= 1'b0;
      overlap <= 1'b0;
    end else if (ctrl.load) begin
      idx     <= '0;
      rd_vld  <= 1'b0;
      overlap <= 1'b0;
    end else begin
      if (rd_vld && hit) begin
        overlap <= 1'b1;
      end
      rd_vld <= ctrl.scan && !stat.scan_done;
      if (ctrl.scan && !stat.scan_done) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  // Fill count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= ctrl.commit;
      if (ctrl.commit) begin
        count <= count_next;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      accepted     <= store;
      status       <= status_next;
      entries_used <= ENT_W'(count_next);
    end
  end

endmodule

// ===== rtl/irt_ctrl.sv =====
// Controller: sequences capture, table scan and commit of one request.
module irt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  irt_pkg::stat_t stat,
  output logic           busy,
  output irt_pkg::ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    ctrl.load   = 1'b0;
    ctrl.scan   = 1'b0;
    ctrl.commit = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        ctrl.commit = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/interval_reservation_table.sv =====
// A request is captured, the table scan then reads each stored entry in turn, and the result is committed.
// The table scan reads one stored entry per cycle through the single memory read port; a new request
// is taken only once the block is idle again, after the previous result has been committed.
// Reset clears the fill count and control state; stored entries need no clearing pass.
// Each result is shown for one cycle on done and cannot be stalled by the receiver.
// Top level: booking table of non-overlapping half-open intervals.
module interval_reservation_table #(
  parameter int CAPACITY  = irt_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = irt_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [irt_pkg::IN_W-1:0]  req_start,
  input  logic [irt_pkg::IN_W-1:0]  req_end,
  output logic                      done,
  output logic                      accepted,
  output logic [1:0]                status,
  output logic [irt_pkg::ENT_W-1:0] entries_used
);

  irt_pkg::ctrl_t ctrl;
  irt_pkg::stat_t stat;

  // Controller.
  irt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  // Datapath.
  irt_dp #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .req_start    (req_start),
    .req_end      (req_end),
    .done         (done),
    .accepted     (accepted),
    .status       (status),
    .entries_used (entries_used)
  );

  // A result is only shown once the block has gone idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted request makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The accept flag agrees with the status code.
  a_flag_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (accepted == (status == irt_pkg::ST_OK)))
    else $error("accept flag and status disagree");

  // Each result follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in work");

endmodule
